// ===== hw/rtl/fsla_pkg.sv =====
`timescale 1ns / 1ps
package fsla_pkg;

   // fixed field widths
   localparam int SLOT_W      = 14;
   localparam int OFF_W       = 10;
   localparam int PAGE_W      = SLOT_W - OFF_W;
   localparam int PCNT_W      = PAGE_W + 1;
   localparam int ADDR_W      = 16;
   localparam int SIZE_W      = 13;
   localparam int ARENA_PAGES = 1 << PAGE_W;
   localparam int MIN_SIZE    = 4;
   localparam int RESET_SIZE  = 4;

   // item command codes
   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_OUT
   } state_type;

   // one free list link as stored in the link memory
   typedef struct packed {
      logic              is_end;
      logic [SLOT_W-1:0] next;
   } link_type;

   // page threading request from the controller
   typedef struct packed {
      logic              start;
      logic [PAGE_W-1:0] page;
   } sweep_start_type;

   // page threading progress back to the controller
   typedef struct packed {
      logic              active;
      logic [PAGE_W-1:0] page;
      logic [OFF_W-1:0]  off;
   } sweep_status_type;

endpackage

// ===== hw/rtl/fsla_req_if.sv =====
`timescale 1ns / 1ps
interface fsla_req_if import fsla_pkg::*; ();
   logic              valid;
   logic              ready;
   cmd_type           command;
   logic [SLOT_W-1:0] slot_index;

   modport source (output valid, output command, output slot_index, input ready);
   modport sink   (input valid, input command, input slot_index, output ready);
endinterface

// ===== hw/rtl/fsla_rsp_if.sv =====
`timescale 1ns / 1ps
interface fsla_rsp_if import fsla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              ok;
   logic [SLOT_W-1:0] granted_slot;
   logic [ADDR_W-1:0] byte_address;

   modport source (output valid, output ok, output granted_slot, output byte_address,
                   input ready);
   modport sink   (input valid, input ok, input granted_slot, input byte_address,
                   output ready);
endinterface

// ===== hw/rtl/fsla_link_mem.sv =====
`timescale 1ns / 1ps
module fsla_link_mem import fsla_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  link_type          wr_link,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output link_type          rd_link
);

   localparam int DEPTH = 1 << SLOT_W;

   link_type link_ram_ff [DEPTH];
   link_type rd_link_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_ram_ff[wr_addr] <= wr_link;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_link_ff <= link_ram_ff[rd_addr];
      end
   end

   assign rd_link = rd_link_ff;

endmodule

// ===== hw/rtl/fsla_page_sweep.sv =====
`timescale 1ns / 1ps
module fsla_page_sweep import fsla_pkg::*; #(
   parameter int PAGE_SIZE = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sweep_start_type                  start,
   input  logic [$clog2(PAGE_SIZE+1)-1:0]   eff_size,
   input  logic                             hold,
   output sweep_status_type                 status,
   output logic                             wr_en,
   output logic [SLOT_W-1:0]                wr_addr,
   output link_type                         wr_link
);

   localparam int EFF_W = $clog2(PAGE_SIZE + 1);
   localparam int ACC_W = EFF_W + 1;

   logic              active_ff, active_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [EFF_W-1:0]  eff_ff, eff_in;
   logic [ACC_W-1:0]  acc_next;
   logic              last_slot;

   // acc holds the byte offset just past the current slot
   assign acc_next  = acc_ff + ACC_W'(eff_ff);
   assign last_slot = (acc_next > ACC_W'(PAGE_SIZE)) || (off_ff == '1);

   // link write for the slot under the cursor
   assign wr_en        = active_ff && !hold;
   assign wr_addr      = {page_ff, off_ff};
   assign wr_link.next = wr_addr + SLOT_W'(1);
   assign wr_link.is_end = last_slot;

   assign status.active = active_ff;
   assign status.page   = page_ff;
   assign status.off    = off_ff;

   // cursor advance
   always_comb begin
      active_in = active_ff;
      page_in   = page_ff;
      off_in    = off_ff;
      acc_in    = acc_ff;
      eff_in    = eff_ff;
      if (start.start) begin
         active_in = 1'b1;
         page_in   = start.page;
         off_in    = '0;
         acc_in    = ACC_W'(eff_size);
         eff_in    = eff_size;
      end else if (wr_en) begin
         if (last_slot) begin
            active_in = 1'b0;
         end else begin
            off_in = off_ff + OFF_W'(1);
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      off_ff  <= off_in;
      acc_ff  <= acc_in;
      eff_ff  <= eff_in;
   end

endmodule

// ===== hw/rtl/fixed_slot_free_list_allocator.sv =====
`timescale 1ns / 1ps
// Fixed-size slot allocator with a LIFO free list kept in a 16K x 15 link
// memory (one read and one write port, registered read). A free goes through
// accept, link write and output load; an allocate that pops the list adds a
// link memory read before the output load. When the list runs dry, an
// allocate threads the next unused page: a background cursor writes one link
// per clock while no free holds the write port, and an item that touches a
// slot of that page not yet threaded waits for the cursor to pass it. The
// result register lets a new item be taken while a result waits. The user
// must set the element size through the csr port only while no item is in
// flight; the block itself does not enforce it.
module fixed_slot_free_list_allocator import fsla_pkg::*; #(
   parameter int PAGE_SIZE = 4096,
   parameter int MAX_PAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   fsla_req_if.sink          req_chan,
   fsla_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [SIZE_W-1:0] csr_write_data
);

   localparam int EFF_W      = $clog2(PAGE_SIZE + 1);
   localparam int CMP_W      = (EFF_W > SIZE_W) ? EFF_W : SIZE_W;
   localparam int PROD_W     = OFF_W + EFF_W;
   localparam int PAGE_LIMIT = (MAX_PAGES < ARENA_PAGES) ? MAX_PAGES : ARENA_PAGES;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   cmd_type           cmd_ff, cmd_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic              empty_ff, empty_in;
   logic [PCNT_W-1:0] pages_used_ff, pages_used_in;
   logic              res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic [EFF_W-1:0]  eff_size;
   sweep_start_type   sweep_start;
   sweep_status_type  sweep_status;
   logic              sweep_wr_en;
   logic [SLOT_W-1:0] sweep_wr_addr;
   link_type          sweep_wr_link;
   logic              free_wr_en;
   link_type          free_wr_link;
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   link_type          mem_wr_link;
   logic              mem_rd_en;
   link_type          mem_rd_link;
   logic              slot_pending;
   logic              head_pending;
   logic [31:0]       page_base;
   logic [PROD_W-1:0] off_prod;
   logic [ADDR_W-1:0] grant_addr;

   // effective element size, clamped to [4, PAGE_SIZE]
   always_comb begin
      if (size_ff < SIZE_W'(MIN_SIZE)) begin
         eff_size = EFF_W'(MIN_SIZE);
      end else if (CMP_W'(size_ff) > CMP_W'(PAGE_SIZE)) begin
         eff_size = EFF_W'(PAGE_SIZE);
      end else begin
         eff_size = EFF_W'(size_ff);
      end
   end

   // slot lies in the page being threaded at or past the cursor
   assign slot_pending = sweep_status.active
                         && (slot_ff[SLOT_W-1:OFF_W] == sweep_status.page)
                         && (slot_ff[OFF_W-1:0] >= sweep_status.off);
   assign head_pending = sweep_status.active
                         && (head_ff[SLOT_W-1:OFF_W] == sweep_status.page)
                         && (head_ff[OFF_W-1:0] >= sweep_status.off);

   // byte address of the pending result slot
   assign page_base  = 32'(res_slot_ff[SLOT_W-1:OFF_W]) * 32'(PAGE_SIZE);
   assign off_prod   = PROD_W'(res_slot_ff[OFF_W-1:0]) * PROD_W'(eff_size);
   assign grant_addr = page_base[ADDR_W-1:0] + off_prod[ADDR_W-1:0];

   // free writes win the link memory write port, the cursor waits
   assign free_wr_link.is_end = empty_ff;
   assign free_wr_link.next   = head_ff;
   assign mem_wr_en   = free_wr_en || sweep_wr_en;
   assign mem_wr_addr = free_wr_en ? slot_ff : sweep_wr_addr;
   assign mem_wr_link = free_wr_en ? free_wr_link : sweep_wr_link;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      head_in       = head_ff;
      empty_in      = empty_ff;
      pages_used_in = pages_used_ff;
      res_ok_in     = res_ok_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_addr_in   = rsp_addr_ff;
      free_wr_en    = 1'b0;
      mem_rd_en     = 1'b0;
      sweep_start.start = 1'b0;
      sweep_start.page  = pages_used_ff[PAGE_W-1:0];
      req_chan.ready    = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               slot_in  = req_chan.slot_index;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd_ff == CMD_FREE) begin
               // push onto the head
               if (!slot_pending) begin
                  free_wr_en  = 1'b1;
                  head_in     = slot_ff;
                  empty_in    = 1'b0;
                  res_ok_in   = 1'b1;
                  res_slot_in = '0;
                  state_in    = ST_OUT;
               end
            end else if (empty_ff) begin
               // refill from the next unused page, or out of memory
               if (pages_used_ff >= PCNT_W'(PAGE_LIMIT)) begin
                  res_ok_in   = 1'b0;
                  res_slot_in = '0;
                  state_in    = ST_OUT;
               end else if (!sweep_status.active) begin
                  sweep_start.start = 1'b1;
                  head_in       = {pages_used_ff[PAGE_W-1:0], {OFF_W{1'b0}}};
                  empty_in      = 1'b0;
                  pages_used_in = pages_used_ff + PCNT_W'(1);
               end
            end else if (!head_pending) begin
               // pop: fetch the link of the head
               mem_rd_en = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            res_ok_in   = 1'b1;
            res_slot_in = head_ff;
            if (mem_rd_link.is_end) begin
               empty_in = 1'b1;
               head_in  = '0;
            end else begin
               head_in = mem_rd_link.next;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_addr_in  = grant_addr;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         empty_ff      <= 1'b1;
         pages_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         size_ff       <= SIZE_W'(RESET_SIZE);
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         empty_ff      <= empty_in;
         pages_used_ff <= pages_used_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = rsp_ok_ff;
   assign rsp_chan.granted_slot = rsp_slot_ff;
   assign rsp_chan.byte_address = rsp_addr_ff;

   // page threading cursor
   fsla_page_sweep #(
      .PAGE_SIZE (PAGE_SIZE)
   ) u_sweep (
      .clock    (clock),
      .reset    (reset),
      .start    (sweep_start),
      .eff_size (eff_size),
      .hold     (free_wr_en),
      .status   (sweep_status),
      .wr_en    (sweep_wr_en),
      .wr_addr  (sweep_wr_addr),
      .wr_link  (sweep_wr_link)
   );

   // free list links
   fsla_link_mem u_link_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_link (mem_wr_link),
      .rd_en   (mem_rd_en),
      .rd_addr (head_ff),
      .rd_link (mem_rd_link)
   );

endmodule
